// File: hdl/frms_pkg.sv
// frms_pkg: shared widths, reset values, register indexes and struct types
// for the frequency / rocof stability monitor
// no dependencies
package frms_pkg;

    localparam int COUNT_W = 16;
    localparam int SR_W    = 16;
    localparam int FREQ_W  = 24;
    localparam int ROC_W   = 32;
    localparam int SUM_W   = FREQ_W + 1;
    localparam int REM_W   = SUM_W;
    localparam int DQ_W    = 41;
    localparam int PROD_W  = 2 * FREQ_W;
    localparam int MUL_W   = PROD_W + 1;
    localparam int NUM_W   = 73;
    localparam int CNT_W   = 6;

    localparam int DIV1_STEPS = FREQ_W;
    localparam int DIV2_STEPS = DQ_W;

    localparam logic [SR_W-1:0]   SAMPLE_RATE_RST = 16'd16000;
    localparam logic [FREQ_W-1:0] MIN_FREQ_RST    = 24'd12416;
    localparam logic [ROC_W-1:0]  MAX_ROCOF_RST   = 32'd5120;
    localparam logic [FREQ_W-1:0] PREV_FREQ_RST   = 24'd12800;

    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_MIN_FREQ    = 2'd1;
    localparam logic [1:0] REG_MAX_ROCOF   = 2'd2;

    typedef struct packed {
        logic [SR_W-1:0]          sample_rate_hz;
        logic [FREQ_W-1:0]        min_frequency_q8;
        logic signed [ROC_W-1:0]  max_rocof_q8;
    } cfg_t;

    typedef struct packed {
        logic [FREQ_W-1:0]        frequency_q8;
        logic signed [ROC_W-1:0]  rocof_q8;
        logic                     stable;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } stat_t;

endpackage

// File: hdl/frms_div_step.sv
// frms_div_step: one restoring divide step, shared by both divisions
// depends on frms_pkg
module frms_div_step (
    input  logic [frms_pkg::REM_W-1:0] rem_in,
    input  logic                       bit_in,
    input  logic [frms_pkg::REM_W-1:0] divisor,
    output logic [frms_pkg::REM_W-1:0] rem_out,
    output logic                       q_bit
);

    logic [frms_pkg::REM_W:0] trial;
    logic [frms_pkg::REM_W:0] diff;

    always_comb begin
        trial   = {rem_in, bit_in};
        diff    = trial - {1'b0, divisor};
        q_bit   = (trial >= {1'b0, divisor});
        rem_out = q_bit ? diff[frms_pkg::REM_W-1:0] : trial[frms_pkg::REM_W-1:0];
    end

endmodule

// File: hdl/frms_core.sv
// frms_core: sequencer and datapath; frequency divide, product build,
// rocof divide on one shared step unit and one shared multiplier
// depends on frms_pkg, frms_div_step
module frms_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [frms_pkg::COUNT_W-1:0]  period_count,
    input  frms_pkg::cfg_t                cfg,
    input  logic                          out_free,
    output frms_pkg::stat_t               stat,
    output frms_pkg::res_t                res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV1 = 3'd1;
    localparam logic [2:0] ST_MUL0 = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_DIV2 = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]                        state_reg, state_next;
    logic [frms_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [frms_pkg::REM_W-1:0]        div_reg, div_next;
    logic [frms_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [frms_pkg::DQ_W-1:0]         dq_reg, dq_next;
    logic [frms_pkg::FREQ_W-1:0]       f_reg, f_next;
    logic [frms_pkg::FREQ_W-1:0]       prev_reg, prev_next;
    logic                              neg_reg, neg_next;
    logic                              zero_reg, zero_next;
    logic [frms_pkg::PROD_W-1:0]       p_reg, p_next;
    logic [frms_pkg::MUL_W-1:0]        lo_reg, lo_next;
    logic [frms_pkg::PROD_W-1:0]       hi_reg, hi_next;

    logic [frms_pkg::REM_W-1:0]        step_rem;
    logic                              step_q;
    logic [frms_pkg::FREQ_W:0]         mul_a;
    logic [frms_pkg::FREQ_W-1:0]       mul_b;
    logic [frms_pkg::MUL_W-1:0]        mul_p;
    logic [frms_pkg::FREQ_W-1:0]       f_new;
    logic                              f_lt;
    logic [frms_pkg::FREQ_W-1:0]       mag;
    logic [frms_pkg::NUM_W-1:0]        num;
    logic [frms_pkg::DQ_W-1:0]         q;
    logic signed [frms_pkg::DQ_W:0]    roc;
    logic signed [frms_pkg::DQ_W:0]    max_ext;
    logic [frms_pkg::COUNT_W-1:0]      count_fix;
    logic                              sat_hi;
    logic                              sat_lo;

    frms_div_step u_step (
        .rem_in  (rem_reg),
        .bit_in  (dq_reg[frms_pkg::DQ_W-1]),
        .divisor (div_reg),
        .rem_out (step_rem),
        .q_bit   (step_q)
    );

    // shared 25x24 multiplier
    assign mul_p = {{frms_pkg::FREQ_W{1'b0}}, mul_a}
                 * {{(frms_pkg::FREQ_W + 1){1'b0}}, mul_b};

    always_comb begin
        f_new     = dq_reg[frms_pkg::FREQ_W-1:0];
        f_lt      = f_new < prev_reg;
        mag       = f_lt ? (prev_reg - f_new) : (f_new - prev_reg);
        count_fix = (period_count == '0) ? frms_pkg::COUNT_W'(1) : period_count;
        num       = {{(frms_pkg::NUM_W - frms_pkg::MUL_W){1'b0}}, lo_reg}
                  + {hi_reg, {(frms_pkg::NUM_W - frms_pkg::PROD_W){1'b0}}};

        mul_a = {1'b0, mag};
        mul_b = f_new;
        case (state_reg)
            ST_MUL1: begin
                mul_a = {p_reg[frms_pkg::FREQ_W-1:0], 1'b0};
                mul_b = prev_reg;
            end
            ST_MUL2: begin
                mul_a = {1'b0, p_reg[frms_pkg::PROD_W-1:frms_pkg::FREQ_W]};
                mul_b = prev_reg;
            end
            default: begin
                mul_a = {1'b0, mag};
                mul_b = f_new;
            end
        endcase

        // sign, saturation and threshold checks
        q       = zero_reg ? '0 : dq_reg;
        roc     = neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        max_ext = {{(frms_pkg::DQ_W + 1 - frms_pkg::ROC_W){cfg.max_rocof_q8[frms_pkg::ROC_W-1]}},
                   cfg.max_rocof_q8};
        sat_hi  = !neg_reg && (q[frms_pkg::DQ_W-1:frms_pkg::ROC_W-1] != '0);
        sat_lo  = neg_reg && ((q[frms_pkg::DQ_W-1:frms_pkg::ROC_W] != '0)
                  || (q[frms_pkg::ROC_W-1] && (q[frms_pkg::ROC_W-2:0] != '0)));

        res.frequency_q8 = f_reg;
        if (sat_hi) begin
            res.rocof_q8 = {1'b0, {(frms_pkg::ROC_W-1){1'b1}}};
        end else if (sat_lo) begin
            res.rocof_q8 = {1'b1, {(frms_pkg::ROC_W-1){1'b0}}};
        end else begin
            res.rocof_q8 = roc[frms_pkg::ROC_W-1:0];
        end
        res.stable = (f_reg >= cfg.min_frequency_q8) && !(roc > max_ext);

        stat.idle = (state_reg == ST_IDLE);
        stat.done = (state_reg == ST_FIN) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        f_next     = f_reg;
        prev_next  = prev_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        p_next     = p_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    div_next   = {{(frms_pkg::REM_W - frms_pkg::COUNT_W){1'b0}}, count_fix};
                    rem_next   = '0;
                    dq_next    = {cfg.sample_rate_hz, 8'h00, 17'h0};
                    cnt_next   = frms_pkg::CNT_W'(frms_pkg::DIV1_STEPS - 1);
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1, ST_DIV2: begin
                rem_next = step_rem;
                dq_next  = {dq_reg[frms_pkg::DQ_W-2:0], step_q};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = (state_reg == ST_DIV1) ? ST_MUL0 : ST_FIN;
                end
            end
            ST_MUL0: begin
                f_next     = f_new;
                neg_next   = f_lt;
                zero_next  = (mag == '0);
                div_next   = {1'b0, f_new} + {1'b0, prev_reg};
                p_next     = mul_p[frms_pkg::PROD_W-1:0];
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                lo_next    = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                hi_next    = mul_p[frms_pkg::PROD_W-1:0];
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // drop the 8 fraction bits; top bits always stay below the divisor
                rem_next   = {1'b0, num[frms_pkg::NUM_W-1:frms_pkg::DQ_W+8]};
                dq_next    = num[frms_pkg::DQ_W+7:8];
                cnt_next   = frms_pkg::CNT_W'(frms_pkg::DIV2_STEPS - 1);
                state_next = ST_DIV2;
            end
            ST_FIN: begin
                if (out_free) begin
                    prev_next  = f_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            prev_reg  <= frms_pkg::PREV_FREQ_RST;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        f_reg    <= f_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        p_reg    <= p_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
    end

endmodule

// File: hdl/frequency_rocof_stability_monitor_top.sv
// frequency_rocof_stability_monitor_top: stream ports, apb register file,
// output register; depends on frms_pkg, frms_core
// one beat at a time: start, 24 + 41 shared divide steps, 4 multiply/setup, finish, then m_tvalid;
// finish waits until the output register is free, and only then is a new beat taken
// s_tready is high while the core is idle; a finished result may wait in the output register
// reset: synchronous active low; registers return to their defaults, previous frequency to 50 Hz
module frequency_rocof_stability_monitor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] period_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [23:0] frequency_q8, [55:24] rocof_q8
    output logic        m_tuser,   // [0] stable
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    frms_pkg::cfg_t   cfg_reg, cfg_next;
    frms_pkg::stat_t  stat;
    frms_pkg::res_t   res;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [55:0]      m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;
    logic             out_free;
    logic             wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = stat.idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    frms_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_tvalid && s_tready),
        .period_count (s_tdata[frms_pkg::COUNT_W-1:0]),
        .cfg          (cfg_reg),
        .out_free     (out_free),
        .stat         (stat),
        .res          (res)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                frms_pkg::REG_SAMPLE_RATE: cfg_next.sample_rate_hz   = pwdata[15:0];
                frms_pkg::REG_MIN_FREQ:    cfg_next.min_frequency_q8 = pwdata[23:0];
                frms_pkg::REG_MAX_ROCOF:   cfg_next.max_rocof_q8     = pwdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            frms_pkg::REG_SAMPLE_RATE: prdata = {16'h0, cfg_reg.sample_rate_hz};
            frms_pkg::REG_MIN_FREQ:    prdata = {8'h0, cfg_reg.min_frequency_q8};
            frms_pkg::REG_MAX_ROCOF:   prdata = cfg_reg.max_rocof_q8;
            default:                   prdata = '0;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (stat.done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res.rocof_q8, res.frequency_q8};
            m_tuser_next  = res.stable;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_rate_hz   <= frms_pkg::SAMPLE_RATE_RST;
            cfg_reg.min_frequency_q8 <= frms_pkg::MIN_FREQ_RST;
            cfg_reg.max_rocof_q8     <= frms_pkg::MAX_ROCOF_RST;
            m_tvalid_reg             <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

// File: hdl/frms_checker.sv
// frms_checker: port-level checks on the monitor top level, bound in below
// depends on frequency_rocof_stability_monitor_top
module frms_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser
);

    // accepting a beat starts a long computation
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a beat");

    // a new result only comes from a busy core
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in flight");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind frequency_rocof_stability_monitor_top frms_checker u_frms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/tb.sv
// tb: self-checking bench for frequency_rocof_stability_monitor_top, covering
// period stream, register port, stalls and saturation of the rate of change
// depends on frms_pkg and the monitor rtl
module tb;
    import frms_pkg::*;

    localparam int          PERIOD_NS  = 10;
    localparam int          CYCLE_CAP  = 500000;
    localparam int          SETTLE     = 80;
    localparam int          HOLD_LEN   = 400;
    localparam int          IDLE_PCT   = 38;
    localparam logic [1:0]  REG_UNUSED = 2'd3;

    class rocof_scoreboard;
        logic [SR_W-1:0]          rate;
        logic [FREQ_W-1:0]        min_freq;
        logic signed [ROC_W-1:0]  max_roc;
        logic [FREQ_W-1:0]        last_freq;
        res_t                     pending_readings[$];
        int                       errors;
        int                       readings_seen;
        int                       saturations;
        int                       unstable_seen;

        function new();
            rate      = SAMPLE_RATE_RST;
            min_freq  = MIN_FREQ_RST;
            max_roc   = MAX_ROCOF_RST;
            last_freq = PREV_FREQ_RST;
            errors    = 0;
            readings_seen = 0;
            saturations   = 0;
            unstable_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SAMPLE_RATE: rate     = value[SR_W-1:0];
                REG_MIN_FREQ:    min_freq = value[FREQ_W-1:0];
                REG_MAX_ROCOF:   max_roc  = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_SAMPLE_RATE: return {16'd0, rate};
                REG_MIN_FREQ:    return {8'd0, min_freq};
                REG_MAX_ROCOF:   return max_roc;
                default:         return 32'd0;
            endcase
        endfunction

        function void mismatch(string what, longint want, longint got);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        // frequency from the period, then rate of change against the last frequency
        function void note_period(logic [COUNT_W-1:0] count);
            logic [31:0]         scaled;
            logic [31:0]         divisor;
            logic [FREQ_W-1:0]   freq;
            logic [FREQ_W-1:0]   delta;
            logic                falling;
            logic [127:0]        numer;
            logic [127:0]        denom;
            logic [127:0]        quot;
            longint              roc;
            res_t                r;
            divisor = (count == 0) ? 32'd1 : {16'd0, count};
            scaled  = {8'd0, rate, 8'd0};
            freq    = FREQ_W'(scaled / divisor);
            falling = freq < last_freq;
            delta   = falling ? last_freq - freq : freq - last_freq;
            denom   = 128'd256 * (128'(freq) + 128'(last_freq));
            if (denom == 0 || delta == 0) begin
                quot = 0;
            end else begin
                numer = 128'(delta) * 128'd2 * 128'(freq) * 128'(last_freq);
                quot  = numer / denom;
            end
            roc = falling ? -$signed(quot[63:0]) : $signed(quot[63:0]);
            r.frequency_q8 = freq;
            if (roc > 64'sd2147483647) begin
                r.rocof_q8 = 32'sh7fffffff;
                saturations++;
            end else if (roc < -64'sd2147483648) begin
                r.rocof_q8 = 32'sh80000000;
                saturations++;
            end else begin
                r.rocof_q8 = roc[31:0];
            end
            r.stable = !(freq < min_freq || roc > longint'(max_roc));
            if (!r.stable)
                unstable_seen++;
            pending_readings.push_back(r);
            last_freq = freq;
        endfunction

        function void check_reading(logic [FREQ_W-1:0] freq, logic [ROC_W-1:0] roc,
                                    logic stable);
            res_t want;
            if (pending_readings.size() == 0) begin
                mismatch("unexpected beat, frequency", -1, freq);
                return;
            end
            want = pending_readings.pop_front();
            readings_seen++;
            if (freq !== want.frequency_q8)
                mismatch("frequency_q8", want.frequency_q8, freq);
            if (roc !== want.rocof_q8)
                mismatch("rocof_q8", want.rocof_q8, $signed(roc));
            if (stable !== want.stable)
                mismatch("stable", want.stable, stable);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] period_count
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // [23:0] frequency_q8, [55:24] rocof_q8
    logic        m_tuser;    // [0] stable
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rocof_scoreboard sb;
    bit          calm;
    bit          hold_req;
    int          hold_left;
    int          holds_done;
    int          periods_sent;
    int          settings_used;
    int          cycles;

    frequency_rocof_stability_monitor_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #(PERIOD_NS / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("run stopped after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random backpressure, one long hold when asked
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_reading(m_tdata[23:0], m_tdata[55:24], m_tuser);
    end

    task automatic send_period(input logic [15:0] count);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= count;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_period(count);
        periods_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [1:0] idx);
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        if (got !== sb.reg_value(idx))
            sb.mismatch("register readback", sb.reg_value(idx), got);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] rate, input logic [23:0] min_freq,
                             input logic [31:0] max_roc);
        drain();
        apb_write(REG_SAMPLE_RATE, {16'd0, rate});
        apb_write(REG_MIN_FREQ, {8'd0, min_freq});
        apb_write(REG_MAX_ROCOF, max_roc);
        apb_check(REG_SAMPLE_RATE);
        apb_check(REG_MIN_FREQ);
        apb_check(REG_MAX_ROCOF);
        settings_used++;
    endtask

    // mostly slow drift around the nominal grid period, some jumps and noise
    task automatic send_random(input int n);
        int lo;
        int hi;
        int count;
        int pick;
        lo = sb.rate / 53;
        hi = sb.rate / 47 + 1;
        if (hi > 65535)
            hi = 65535;
        count = (lo + hi) / 2;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                count = $urandom_range(0, 65535);
            end else if (pick < 35) begin
                count = $urandom_range(lo, hi);
            end else begin
                count = count + int'($urandom_range(0, 6)) - 3;
                if (count < lo || count > hi)
                    count = (lo + hi) / 2;
            end
            send_period(count[15:0]);
        end
        stop_sending();
    endtask

    initial begin
        sb            = new();
        calm          = 1'b0;
        hold_req      = 1'b0;
        holds_done    = 0;
        periods_sent  = 0;
        settings_used = 1;
        cycles        = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults after reset
        apb_check(REG_SAMPLE_RATE);
        apb_check(REG_MIN_FREQ);
        apb_check(REG_MAX_ROCOF);
        send_period(16'd320);
        send_period(16'd0);
        send_period(16'd1);
        send_period(16'hffff);
        send_period(16'd320);
        send_period(16'd330);
        send_period(16'd310);
        send_period(16'h5555);
        send_period(16'haaaa);
        send_period(16'h8000);
        stop_sending();

        // fastest sample clock, strictest thresholds, large jumps saturate
        configure(16'hffff, 24'hffffff, 32'h80000000);
        send_period(16'd1);
        send_period(16'd2);
        send_period(16'd1);
        send_period(16'd65535);
        send_random(120);

        // zero sample clock, every new frequency zero
        configure(16'd0, 24'd0, 32'd0);
        send_period(16'd5);
        send_period(16'd7);
        send_period(16'd0);
        send_random(20);

        configure(16'd1, 24'd1, 32'h7fffffff);
        send_random(120);

        // nominal grid, with the output held off while periods are still offered
        configure(SAMPLE_RATE_RST, MIN_FREQ_RST, MAX_ROCOF_RST);
        hold_req = 1'b1;
        send_random(200);

        // random settings, no idling on either side
        configure(16'($urandom_range(1, 65535)), 24'($urandom_range(0, 16777215)),
                  $urandom());
        calm = 1'b1;
        send_random(150);
        calm = 1'b0;

        configure(16'd50000, 24'd12800, 32'd256);
        drain();
        apb_write(REG_UNUSED, 32'hdeadbeef);
        apb_check(REG_SAMPLE_RATE);
        apb_check(REG_MIN_FREQ);
        apb_check(REG_MAX_ROCOF);
        send_random(200);

        drain();
        $display("%0d periods sent, %0d readings checked, %0d register settings",
                 periods_sent, sb.readings_seen, settings_used);
        $display("%0d saturated, %0d unstable, %0d long output holds",
                 sb.saturations, sb.unstable_seen, holds_done);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d readings missing", sb.errors, sb.pending());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: frequency_rocof_stability_monitor_top.f
hdl/frms_pkg.sv
hdl/frms_div_step.sv
hdl/frms_core.sv
hdl/frequency_rocof_stability_monitor_top.sv
hdl/frms_checker.sv
verif/tb.sv
